FILE: hdl/int16_to_decimal_ascii_macros.svh
// Assertion macros used by the checker of the decimal text converter.
`ifndef INT16_TO_DECIMAL_ASCII_MACROS_SVH
`define INT16_TO_DECIMAL_ASCII_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2A_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/i2a_pkg.sv
// Types, character codes and decimal weight tables for the decimal text converter.
`timescale 1ns / 1ps

package i2a_pkg;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // Digit position: 0 is units, 4 is ten-thousands.
    typedef logic [2:0]  pos_t;
    typedef logic [3:0]  digit_t;
    typedef logic [15:0] mag_t;

    localparam pos_t POS_UNITS = 3'd0;
    localparam pos_t POS_TENS  = 3'd1;
    localparam pos_t POS_HUND  = 3'd2;
    localparam pos_t POS_THOU  = 3'd3;
    localparam pos_t POS_TTHOU = 3'd4;

    typedef struct packed {
        digit_t digit;
        mag_t   rem;
    } digit_res_t;

    // k times the weight of a digit position; k is a constant at every call site,
    // so each call reduces to a small mux of constants.
    function automatic logic [16:0] multiple(input pos_t pos, input logic [3:0] k);
        case (pos)
            POS_UNITS: return 17'(k);
            POS_TENS:  return 17'(k) * 17'd10;
            POS_HUND:  return 17'(k) * 17'd100;
            POS_THOU:  return 17'(k) * 17'd1000;
            POS_TTHOU: return 17'(k) * 17'd10000;
            default:   return '1;
        endcase
    endfunction

endpackage

FILE: hdl/i2a_if.sv
// Valid/ready channel interfaces for the value input and the character output.
`timescale 1ns / 1ps

interface i2a_value_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] signed_value;

    modport source (output valid, output signed_value, input ready);
    modport sink   (input valid, input signed_value, output ready);
endinterface

interface i2a_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: hdl/i2a_digit.sv
// Extracts one decimal digit and the remainder at a given position of a magnitude.
`timescale 1ns / 1ps

module i2a_digit (
    input  i2a_pkg::mag_t       mag,
    input  i2a_pkg::pos_t       pos,
    output i2a_pkg::digit_res_t res
);

    // The remaining magnitude is always below ten times the weight, so the
    // digit is the largest k whose multiple does not exceed it.
    always_comb
    begin
        res.digit = '0;
        res.rem   = mag;
        for (int k = 1; k < 10; k++)
        begin
            if ({1'b0, mag} >= i2a_pkg::multiple(pos, 4'(k)))
            begin
                res.digit = 4'(k);
                res.rem   = 16'({1'b0, mag} - i2a_pkg::multiple(pos, 4'(k)));
            end
        end
    end

endmodule

FILE: hdl/int16_to_decimal_ascii.sv
// Top level: signed 16-bit value to decimal ASCII text, one character per beat.
`timescale 1ns / 1ps

// Each value beat produces its decimal text as a run of one to six character
// beats: a '-' for negative values, then the digits with leading zeros
// suppressed, the units digit always present and flagged with last_char.
// The most negative value renders as "-32768". The character sequencer emits
// one character per cycle while the output register is empty or draining, and
// a value holds it until all of its characters (1 to 6) have left. A value beat
// waits in the input register and moves into the sequencer in the same cycle
// the previous run's units digit leaves, so runs follow with no gap. An accepted
// value passes the input register and the sequencer registers before its first
// character reaches the output register.
// An output register decouples the sequencer from the sink; a stalled output
// holds its beat steady. No state carries over between values.
module int16_to_decimal_ascii (
    input  logic         clk,
    input  logic         rst_n,
    i2a_value_if.sink    value_chan,
    i2a_char_if.source   char_chan
);

    // Input register.
    logic               in_valid_reg;
    logic               in_valid_next;
    logic signed [15:0] in_value_reg;

    // Character sequencer.
    logic               busy_reg;
    logic               busy_next;
    logic               minus_reg;
    logic               minus_next;
    i2a_pkg::pos_t      pos_reg;
    i2a_pkg::pos_t      pos_next;
    i2a_pkg::mag_t      mag_reg;
    i2a_pkg::mag_t      mag_next;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         char_reg;
    logic [7:0]         char_next;
    logic               last_reg;
    logic               last_next;

    logic               seq_adv;
    logic               seq_done;
    logic               load;
    logic               load_neg;
    i2a_pkg::mag_t      load_mag;
    i2a_pkg::pos_t      load_pos;
    i2a_pkg::digit_res_t digit_res;

    // The sequencer steps whenever the output register is empty or is being
    // drained this cycle. It finishes on the units digit.
    assign seq_adv  = busy_reg && (!out_valid_reg || char_chan.ready);
    assign seq_done = seq_adv && !minus_reg && (pos_reg == i2a_pkg::POS_UNITS);
    assign load     = in_valid_reg && (!busy_reg || seq_done);

    assign value_chan.ready = !in_valid_reg || load;

    // Magnitude modulo 2^16, which maps -32768 onto 32768.
    assign load_neg = in_value_reg[15];
    assign load_mag = load_neg ? (16'd0 - $unsigned(in_value_reg)) : $unsigned(in_value_reg);

    // The first shown digit is the highest nonzero one; zero starts at units.
    always_comb
    begin
        if (load_mag >= 16'd10000)
        begin
            load_pos = i2a_pkg::POS_TTHOU;
        end
        else if (load_mag >= 16'd1000)
        begin
            load_pos = i2a_pkg::POS_THOU;
        end
        else if (load_mag >= 16'd100)
        begin
            load_pos = i2a_pkg::POS_HUND;
        end
        else if (load_mag >= 16'd10)
        begin
            load_pos = i2a_pkg::POS_TENS;
        end
        else
        begin
            load_pos = i2a_pkg::POS_UNITS;
        end
    end

    i2a_digit u_digit (
        .mag (mag_reg),
        .pos (pos_reg),
        .res (digit_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (value_chan.valid && value_chan.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        minus_next = minus_reg;
        pos_next   = pos_reg;
        mag_next   = mag_reg;
        if (seq_adv)
        begin
            if (minus_reg)
            begin
                minus_next = 1'b0;
            end
            else
            begin
                mag_next = digit_res.rem;
                pos_next = pos_reg - 3'd1;
            end
        end
        if (seq_done)
        begin
            busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next  = 1'b1;
            minus_next = load_neg;
            pos_next   = load_pos;
            mag_next   = load_mag;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (seq_adv)
        begin
            out_valid_next = 1'b1;
            char_next      = minus_reg ? i2a_pkg::CHAR_MINUS
                                       : i2a_pkg::CHAR_ZERO + {4'd0, digit_res.digit};
            last_next      = !minus_reg && (pos_reg == i2a_pkg::POS_UNITS);
        end
        else if (char_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            minus_reg     <= 1'b0;
            pos_reg       <= i2a_pkg::POS_UNITS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            busy_reg      <= busy_next;
            minus_reg     <= minus_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_chan.valid && value_chan.ready)
        begin
            in_value_reg <= value_chan.signed_value;
        end
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign char_chan.valid     = out_valid_reg;
    assign char_chan.char_code = char_reg;
    assign char_chan.last_char = last_reg;

endmodule

FILE: hdl/i2a_checker.sv
// Port-level assertions on the character output of the converter, with its bind.
`timescale 1ns / 1ps
`include "int16_to_decimal_ascii_macros.svh"

module i2a_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char_code,
    input logic       last_char
);

    logic       stalled;
    logic       is_minus;
    logic       is_digit;
    logic       minus_beat;
    logic [8:0] beat_bits;

    assign stalled    = out_valid && !out_ready;
    assign is_minus   = (char_code == i2a_pkg::CHAR_MINUS);
    assign is_digit   = (char_code >= i2a_pkg::CHAR_ZERO) && (char_code <= i2a_pkg::CHAR_NINE);
    assign minus_beat = out_valid && is_minus;
    assign beat_bits  = {char_code, last_char};

    // A stalled character beat keeps its contents.
    `I2A_ASSERT_NEXT(a_stall_hold, stalled, out_valid && $stable(beat_bits), "stalled beat changed")

    // Every character is a minus sign or a decimal digit.
    `I2A_ASSERT_SAME(a_char_set, out_valid, is_minus || is_digit, "character not minus or digit")

    // The sign never ends a run.
    `I2A_ASSERT_SAME(a_minus_not_last, minus_beat, !last_char, "minus sign marked as last")

    // A taken minus sign is never directly followed by another sign.
    `I2A_ASSERT_NEXT(a_no_double_minus, minus_beat && out_ready, !minus_beat, "two minus signs")

endmodule

bind int16_to_decimal_ascii i2a_checker u_i2a_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (char_chan.valid),
    .out_ready (char_chan.ready),
    .char_code (char_chan.char_code),
    .last_char (char_chan.last_char)
);

FILE: bench/int16_to_decimal_ascii_test.sv
// Self-checking bench for the signed 16-bit to decimal ASCII text converter.
`timescale 1ns / 1ps

// Each value beat sent to the converter is expanded here into the run of
// character beats it should produce: an optional '-', the digits with leading
// zeros dropped, and the units digit flagged as last. Every character beat that
// leaves the block is compared field by field with the oldest character still
// waiting. The value side and the character side both stall at random, except
// in a window of value beats where both run flat out.
module int16_to_decimal_ascii_test;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_COUNT = 206;
    // Percent chance that a side sits idle in a given cycle.
    localparam int IDLE_PERCENT = 26;
    // Value beats in this range are sent and taken with no idling at all.
    localparam int QUIET_FIRST  = 120;
    localparam int QUIET_LAST   = 175;
    // Cycles allowed after the last character.
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    i2a_value_if value_if ();
    i2a_char_if  char_if ();

    int16_to_decimal_ascii dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_chan (value_if.sink),
        .char_chan  (char_if.source)
    );

    // Values to send, in order, and the characters they should turn into.
    logic signed [15:0] value_plan[$];
    char_beat_t         expected_chars[$];

    int  issued_count   = 0;
    int  accepted_count = 0;
    int  error_count    = 0;
    int  cycle_count    = 0;
    logic quiet;

    assign quiet = (accepted_count >= QUIET_FIRST) && (accepted_count < QUIET_LAST);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Expand one value into its expected characters. The magnitude is taken in
    // 16 bits, so the most negative value comes out as 32768 after its '-'.
    task automatic push_decimal_text(input logic signed [15:0] value);
        logic [15:0]  magnitude;
        int unsigned  rest;
        int unsigned  weight;
        int unsigned  digit;
        bit           shown;
        char_beat_t   beat;
        shown = 1'b0;
        if (value[15])
        begin
            beat.code = i2a_pkg::CHAR_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
            magnitude = 16'(-value);
        end
        else
        begin
            magnitude = value;
        end
        rest   = magnitude;
        weight = 10000;
        while (weight > 1)
        begin
            digit = rest / weight;
            // Leading zeros are dropped; once a digit shows, all later ones do.
            if (digit != 0 || shown)
            begin
                beat.code = i2a_pkg::CHAR_ZERO + 8'(digit);
                beat.last = 1'b0;
                expected_chars.push_back(beat);
                shown = 1'b1;
            end
            rest   = rest % weight;
            weight = weight / 10;
        end
        // The units digit always appears, even for zero, and closes the run.
        beat.code = i2a_pkg::CHAR_ZERO + 8'(rest);
        beat.last = 1'b1;
        expected_chars.push_back(beat);
    endtask

    // Value driver. A presented beat is held until the monitor has counted it
    // as taken; only then may the next value go out or the channel go idle.
    // While idle the payload carries junk so the block must honor valid.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            value_if.valid <= 1'b0;
        end
        else if (!value_if.valid || accepted_count == issued_count)
        begin
            if (issued_count < value_plan.size()
                && (quiet || $urandom_range(99) >= IDLE_PERCENT))
            begin
                value_if.valid        <= 1'b1;
                value_if.signed_value <= value_plan[issued_count];
                issued_count          <= issued_count + 1;
            end
            else
            begin
                value_if.valid        <= 1'b0;
                value_if.signed_value <= 16'($urandom);
            end
        end
    end

    // Character sink: ready is redrawn every cycle, so stalls land on every
    // position within a run, including the last digit.
    always @(negedge clk)
    begin
        if (!rst_n)
            char_if.ready <= 1'b0;
        else
            char_if.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Monitor: both channels are sampled at the rising edge, where a beat
    // moves when valid and ready are high together.
    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n)
        begin
            if (value_if.valid && value_if.ready)
            begin
                push_decimal_text(value_if.signed_value);
                accepted_count <= accepted_count + 1;
            end
            if (char_if.valid && char_if.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char beat code=%0d last=%0b",
                                              char_if.char_code, char_if.last_char));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_if.char_code !== want.code)
                        report_mismatch($sformatf("char_code got %0d, wanted %0d",
                                                  char_if.char_code, want.code));
                    if (char_if.last_char !== want.last)
                        report_mismatch($sformatf("last_char got %0b, wanted %0b (code %0d)",
                                                  char_if.last_char, want.last, want.code));
                end
            end
        end
    end

    // A hung block ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int          digits;
        int          top;
        logic [15:0] pick;

        rst_n                 = 1'b0;
        value_if.valid        = 1'b0;
        value_if.signed_value = '0;
        char_if.ready         = 1'b0;

        // Directed values: zero, each digit count at its edges, both ends of
        // the range including the most negative value, and alternating bits.
        value_plan = '{16'sd0, 16'sd1, -16'sd1, 16'sd9, 16'sd10, -16'sd10,
                       16'sd99, 16'sd100, -16'sd100, 16'sd999, 16'sd1000,
                       16'sd9999, 16'sd10000, 16'sd10001, 16'sd20000, 16'sd32767,
                       -16'sd32767, 16'sh8000, 16'sd12345, -16'sd9,
                       16'sh5555, 16'shAAAA, -16'sd10000, 16'sd30506};

        // Random values: half drawn over the whole 16-bit range, half with a
        // chosen digit count so short runs are as common as long ones.
        repeat (RANDOM_COUNT)
        begin
            if ($urandom_range(1) == 0)
            begin
                pick = 16'($urandom);
            end
            else
            begin
                digits = $urandom_range(1, 5);
                top    = (digits == 5) ? 32767 : (10 ** digits) - 1;
                pick   = 16'($urandom_range(top, (digits == 1) ? 0 : 10 ** (digits - 1)));
                if ($urandom_range(1) == 1)
                    pick = -pick;
            end
            value_plan.push_back(pick);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (accepted_count == value_plan.size());
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/i2a_pkg.sv
hdl/i2a_if.sv
hdl/i2a_digit.sv
hdl/int16_to_decimal_ascii.sv
hdl/i2a_checker.sv
bench/int16_to_decimal_ascii_test.sv
